@@ hdl/mrrc_pkg.sv @@
// Shared types and constants for the Modbus read response checker.
package mrrc_pkg;

	localparam int MAX_REGS_DEFAULT = 32;

	localparam int CRC_W = 16;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;
	localparam logic [CNT_W-1:0] LEN_EXTRA_ONE = 9'd5;
	localparam logic [CNT_W-1:0] LEN_EXTRA_TWO = 9'd6;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_TWO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNC     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_CNT  = 2'd3;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LENGTH  = 3'd1,
		ST_CRC     = 3'd2,
		ST_ADDRESS = 3'd3,
		ST_FUNC    = 3'd4,
		ST_COUNT   = 3'd5
	} status_t;

	// Control of the bit-serial CRC unit.
	typedef struct packed {
		logic       init;
		logic       start;
		logic [7:0] data;
	} crc_ctl_t;

endpackage

@@ hdl/mrrc_crc.sv @@
// Bit-serial CRC-16 (reflected) unit, one input bit per clock.
module mrrc_crc (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mrrc_pkg::crc_ctl_t       ctl,
	output logic                     busy,
	output logic [mrrc_pkg::CRC_W-1:0] crc
);
	import mrrc_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic [7:0]       sh_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             fb;

	assign fb = crc_q[0] ^ sh_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
		end else if (ctl.init) begin
			crc_q  <= CRC_INIT;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			sh_q   <= ctl.data;
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			crc_q  <= (crc_q >> 1) ^ (fb ? CRC_POLY : '0);
			sh_q   <= sh_q >> 1;
			cnt_q  <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign crc  = crc_q;

endmodule

@@ hdl/mrrc_regfile.sv @@
// Register value buffer: one write port, one registered read port.
module mrrc_regfile #(
	parameter int DEPTH = mrrc_pkg::MAX_REGS_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);
	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/modbus_read_response_checker_core.sv @@
// Top level of the Modbus RTU read-registers response checker.
// A byte request is accepted and run through the bit-serial CRC; then the block is idle again.
// After the end-of-frame byte a check state sets the status; each result of a good frame then
// needs a value buffer read and is offered in the next cycle, held while the output stalls.
// Throughput is set by the bit-serial CRC loop and the single read port of the value buffer.
// Reset (arst_n low, asynchronous) restores the configuration defaults and clears frame state.
module modbus_read_response_checker_core #(
	parameter int MAX_REGS = mrrc_pkg::MAX_REGS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mrrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	input  logic                          end_of_frame,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [4:0]                    reg_index,
	output logic [15:0]                   reg_value,
	output logic                          last
);
	import mrrc_pkg::*;

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CRC,
		S_CHECK,
		S_READ,
		S_SEND
	} state_t;

	// Configuration registers. The port never stalls a write.
	logic [15:0] exp_addr_q;
	logic        addr_two_q;
	logic [7:0]  func_q;
	logic [5:0]  reg_cnt_q;

	// Per-frame state.
	logic [CNT_W-1:0] byte_cnt_q;
	logic             addr_match_q;
	logic             func_match_q;
	logic             cnt_match_q;
	logic [7:0]       hold_q;
	logic             eof_q;

	// Sequencer and output registers.
	state_t       state_q;
	status_t      status_q;
	logic         out_valid_q;
	logic         last_q;
	logic [AW-1:0] k_q;

	logic in_fire;
	logic out_fire;
	logic frame_done;

	crc_ctl_t         crc_ctl;
	logic             crc_busy;
	logic [CRC_W-1:0] crc_val;

	logic [2:0]       hdr;
	logic             in_body;
	logic [CNT_W-1:0] body_off;
	logic [7:0]       pair_idx;
	logic             wr_en;
	logic [15:0]      rd_data;

	logic             n_ok;
	logic [CNT_W-1:0] exp_len;
	status_t          check_st;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	// The frame state returns to its reset values once the final result is taken.
	assign frame_done = out_fire && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= 16'd1;
			addr_two_q <= 1'b0;
			func_q     <= 8'd3;
			reg_cnt_q  <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXP_ADDR: exp_addr_q <= cfg_data;
				CFG_ADDR_TWO: addr_two_q <= cfg_data[0];
				CFG_FUNC:     func_q     <= cfg_data[7:0];
				CFG_REG_CNT:  reg_cnt_q  <= cfg_data[5:0];
				default:      exp_addr_q <= exp_addr_q;
			endcase
		end
	end

	// Header is three bytes (address, function, byte count), or four when the
	// address takes two bytes. Data bytes after the header pair up high byte first.
	assign hdr      = addr_two_q ? 3'd4 : 3'd3;
	assign in_body  = (byte_cnt_q >= CNT_W'(hdr));
	assign body_off = byte_cnt_q - CNT_W'(hdr);
	assign pair_idx = body_off[CNT_W-1:1];
	assign wr_en    = in_fire && in_body && body_off[0] && (pair_idx < 8'(MAX_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q   <= '0;
			addr_match_q <= 1'b1;
			func_match_q <= 1'b0;
			cnt_match_q  <= 1'b0;
			hold_q       <= '0;
			eof_q        <= 1'b0;
		end else if (frame_done) begin
			byte_cnt_q   <= '0;
			addr_match_q <= 1'b1;
			func_match_q <= 1'b0;
			cnt_match_q  <= 1'b0;
			hold_q       <= '0;
			eof_q        <= 1'b0;
		end else if (in_fire) begin
			eof_q <= end_of_frame;
			if (byte_cnt_q != CNT_MAX) begin
				byte_cnt_q <= byte_cnt_q + CNT_W'(1);
			end
			if (addr_two_q) begin
				if (byte_cnt_q == CNT_W'(0) && rx_byte != exp_addr_q[15:8]) begin
					addr_match_q <= 1'b0;
				end
				if (byte_cnt_q == CNT_W'(1) && rx_byte != exp_addr_q[7:0]) begin
					addr_match_q <= 1'b0;
				end
				if (byte_cnt_q == CNT_W'(2) && rx_byte == func_q) begin
					func_match_q <= 1'b1;
				end
				if (byte_cnt_q == CNT_W'(3) && rx_byte == {1'b0, reg_cnt_q, 1'b0}) begin
					cnt_match_q <= 1'b1;
				end
			end else begin
				if (byte_cnt_q == CNT_W'(0) && rx_byte != exp_addr_q[7:0]) begin
					addr_match_q <= 1'b0;
				end
				if (byte_cnt_q == CNT_W'(1) && rx_byte == func_q) begin
					func_match_q <= 1'b1;
				end
				if (byte_cnt_q == CNT_W'(2) && rx_byte == {1'b0, reg_cnt_q, 1'b0}) begin
					cnt_match_q <= 1'b1;
				end
			end
			if (in_body && !body_off[0]) begin
				hold_q <= rx_byte;
			end
		end
	end

	assign crc_ctl.init  = frame_done;
	assign crc_ctl.start = in_fire;
	assign crc_ctl.data  = rx_byte;

	mrrc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.busy   (crc_busy),
		.crc    (crc_val)
	);

	mrrc_regfile #(
		.DEPTH (MAX_REGS),
		.AW    (AW)
	) u_regfile (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pair_idx[AW-1:0]),
		.wr_data ({hold_q, rx_byte}),
		.rd_en   (state_q == S_READ),
		.rd_addr (k_q),
		.rd_data (rd_data)
	);

	// End-of-frame checks in priority order: length, CRC residue, address,
	// function code, byte count. An out-of-range register count fails on length.
	assign n_ok    = (reg_cnt_q != 6'd0) && (reg_cnt_q <= 6'(MAX_REGS));
	assign exp_len = {2'b00, reg_cnt_q, 1'b0} + (addr_two_q ? LEN_EXTRA_TWO : LEN_EXTRA_ONE);

	always_comb begin
		if (!n_ok || byte_cnt_q != exp_len) begin
			check_st = ST_LENGTH;
		end else if (crc_val != '0) begin
			check_st = ST_CRC;
		end else if (!addr_match_q) begin
			check_st = ST_ADDRESS;
		end else if (!func_match_q) begin
			check_st = ST_FUNC;
		end else if (!cnt_match_q) begin
			check_st = ST_COUNT;
		end else begin
			check_st = ST_OK;
		end
	end

	// Sequencer: wait out the CRC, check at end of frame, then walk the value
	// buffer one entry per result. An error gives a single final result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			k_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CRC;
					end
				end
				S_CRC: begin
					if (!crc_busy) begin
						state_q <= eof_q ? S_CHECK : S_IDLE;
					end
				end
				S_CHECK: begin
					status_q <= check_st;
					k_q      <= '0;
					if (check_st != ST_OK) begin
						out_valid_q <= 1'b1;
						last_q      <= 1'b1;
						state_q     <= S_SEND;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					last_q      <= (6'(k_q) == reg_cnt_q - 6'd1);
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign reg_index = (status_q == ST_OK) ? 5'(k_q) : 5'd0;
	assign reg_value = (status_q == ST_OK) ? rd_data : 16'd0;
	assign last      = last_q;

`ifndef SYNTHESIS
	// No new byte request may be taken while a result is pending.
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("byte accepted while a result is pending");

	// An error result is always the only and final one of its frame.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (last && reg_index == 5'd0 && reg_value == 16'd0))
		else $error("error result is not a lone final result");

	// After a byte request the CRC unit must be running on it.
	a_crc_started: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (crc_busy && !in_ready))
		else $error("CRC unit did not start on an accepted byte");

	// Results of a successful frame come out in ascending register order.
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last && status == ST_OK) |=> ##1
		(reg_index == $past(reg_index, 2) + 5'd1))
		else $error("register index did not advance by one");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Modbus RTU read-registers response checker.
module testbench;

	import mrrc_pkg::*;

	localparam int MAX_REGS = MAX_REGS_DEFAULT;
	localparam int SETTLE_CYCLES = 100;   // settling time for any work still going on
	localparam int BACKLOG_CYCLES = 600;  // long receiver hold-off to back up the block
	localparam int QUIET_LIMIT = 5000;    // cycles without any handshake before giving up
	localparam int RANDOM_BYTES = 300;
	localparam int N_DIRECTED = 8;

	// How a frame is shaped before it is sent byte by byte.
	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_ADDR,
		FR_BAD_FUNC,
		FR_BAD_COUNT,
		FR_BAD_LEN,
		FR_NOISE,
		FR_STUB
	} frame_kind_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct packed {
		status_t     st;
		logic [4:0]  idx;
		logic [15:0] val;
		logic        last;
	} reg_result_t;

	// One row of the directed table: the configuration to use, the frame to send, and,
	// where the outcome is obvious, the status that the single error result must carry.
	typedef struct {
		logic [15:0] addr;
		logic        two;
		logic [7:0]  fc;
		logic [5:0]  cnt;
		frame_kind_t kind;
		fill_t       fill;
		bit          typed;
		status_t     st;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 end_of_frame;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           status;
	logic [4:0]           reg_index;
	logic [15:0]          reg_value;
	logic                 last;

	// Our copy of the configuration registers, kept in step with every write.
	logic [15:0] cfg_addr;
	logic        cfg_two;
	logic [7:0]  cfg_func;
	logic [5:0]  cfg_count;

	// Our copy of the per-frame state of the checker.
	logic [15:0] crc_run;
	logic [8:0]  bytes_seen;
	logic        addr_ok;
	logic        func_seen;
	logic        count_seen;
	logic [7:0]  hold_hi;
	logic [15:0] reg_buf[MAX_REGS];

	reg_result_t   fresh_results[$];   // results of the byte just accepted
	reg_result_t   awaited[$];         // results still to come out of the block, oldest first
	logic [7:0]    frame_bytes[$];     // the frame being sent
	directed_row_t directed_rows[N_DIRECTED];

	bit sender_steady = 1'b0;
	bit backlog_req = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;

	modbus_read_response_checker_core #(
		.MAX_REGS(MAX_REGS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Byte-wise CRC-16 with the reflected polynomial, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		int i;
		c = crc ^ {8'h00, b};
		for (i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_frame();
		crc_run = CRC_INIT;
		bytes_seen = '0;
		addr_ok = 1'b1;
		func_seen = 1'b0;
		count_seen = 1'b0;
		hold_hi = '0;
	endfunction

	// Advances our copy of the checker by one accepted byte. On the end-of-frame byte the
	// results it gives are put in fresh_results.
	function automatic void frame_step(input logic [7:0] b, input logic eof);
		int pos;
		int hdr;
		int n;
		int off;
		int k;
		logic [8:0] extra;
		status_t st;
		reg_result_t r;
		pos = int'(bytes_seen);
		hdr = cfg_two ? 4 : 3;
		n = int'(cfg_count);
		crc_run = crc16_byte(crc_run, b);

		// Header bytes are compared as they arrive, against the configuration of that moment.
		if (cfg_two) begin
			if (pos == 0 && b != cfg_addr[15:8]) addr_ok = 1'b0;
			if (pos == 1 && b != cfg_addr[7:0]) addr_ok = 1'b0;
			if (pos == 2 && b == cfg_func) func_seen = 1'b1;
			if (pos == 3 && b == {1'b0, cfg_count, 1'b0}) count_seen = 1'b1;
		end else begin
			if (pos == 0 && b != cfg_addr[7:0]) addr_ok = 1'b0;
			if (pos == 1 && b == cfg_func) func_seen = 1'b1;
			if (pos == 2 && b == {1'b0, cfg_count, 1'b0}) count_seen = 1'b1;
		end

		// After the header the bytes pair up into big-endian register values; the CRC pair
		// lands in the buffer too, which does no harm.
		if (pos >= hdr) begin
			off = pos - hdr;
			if (off % 2 == 0) begin
				hold_hi = b;
			end else if (off / 2 < MAX_REGS) begin
				reg_buf[off / 2] = {hold_hi, b};
			end
		end

		if (bytes_seen < CNT_MAX)
			bytes_seen++;

		if (!eof)
			return;

		extra = cfg_two ? LEN_EXTRA_TWO : LEN_EXTRA_ONE;
		if (n == 0 || n > MAX_REGS || int'(bytes_seen) != 2 * n + int'(extra))
			st = ST_LENGTH;
		else if (crc_run != 16'h0000)
			st = ST_CRC;
		else if (!addr_ok)
			st = ST_ADDRESS;
		else if (!func_seen)
			st = ST_FUNC;
		else if (!count_seen)
			st = ST_COUNT;
		else
			st = ST_OK;

		if (st != ST_OK) begin
			r.st = st;
			r.idx = '0;
			r.val = '0;
			r.last = 1'b1;
			fresh_results.push_back(r);
		end else begin
			for (k = 0; k < n; k++) begin
				r.st = ST_OK;
				r.idx = 5'(k);
				r.val = reg_buf[k];
				r.last = (k == n - 1);
				fresh_results.push_back(r);
			end
		end
		clear_frame();
	endfunction

	// Builds a frame for the current configuration into frame_bytes. Header faults are put
	// in before the CRC is worked out, so that only the intended check fails.
	function automatic void build_frame(input frame_kind_t kind, input fill_t fill);
		logic [7:0]  a_hi;
		logic [7:0]  a_lo;
		logic [7:0]  f;
		logic [7:0]  c;
		logic [15:0] val;
		logic [15:0] crc;
		int words;
		int len;
		int i;
		frame_bytes.delete();
		if (kind == FR_NOISE || kind == FR_STUB) begin
			len = (kind == FR_STUB) ? 1 : $urandom_range(1, 12);
			for (i = 0; i < len; i++)
				frame_bytes.push_back(8'($urandom));
			return;
		end

		a_hi = cfg_addr[15:8];
		a_lo = cfg_addr[7:0];
		f = cfg_func;
		c = {1'b0, cfg_count, 1'b0};
		// With a register count out of range every frame fails on length, so a few words do.
		words = (cfg_count >= 1 && cfg_count <= MAX_REGS) ? int'(cfg_count) : $urandom_range(0, 3);
		case (kind)
			FR_BAD_ADDR: begin
				if (cfg_two && $urandom_range(0, 1) == 1)
					a_hi ^= 8'($urandom_range(1, 255));
				else
					a_lo ^= 8'($urandom_range(1, 255));
			end
			FR_BAD_FUNC: f ^= 8'($urandom_range(1, 255));
			FR_BAD_COUNT: c ^= 8'($urandom_range(1, 255));
			default: ;
		endcase

		if (cfg_two)
			frame_bytes.push_back(a_hi);
		frame_bytes.push_back(a_lo);
		frame_bytes.push_back(f);
		frame_bytes.push_back(c);
		for (i = 0; i < words; i++) begin
			val = (fill == FILL_ZERO) ? 16'h0000 : (fill == FILL_ONES) ? 16'hFFFF : 16'($urandom);
			frame_bytes.push_back(val[15:8]);
			frame_bytes.push_back(val[7:0]);
		end
		crc = CRC_INIT;
		foreach (frame_bytes[j])
			crc = crc16_byte(crc, frame_bytes[j]);
		// Modbus sends the CRC low byte first, which leaves a zero residue.
		frame_bytes.push_back(crc[7:0]);
		frame_bytes.push_back(crc[15:8]);

		if (kind == FR_BAD_CRC) begin
			i = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[i] ^= 8'($urandom_range(1, 255));
		end else if (kind == FR_BAD_LEN) begin
			if ($urandom_range(0, 1) == 1)
				frame_bytes.delete(frame_bytes.size() - 1);
			else
				frame_bytes.push_back(8'($urandom));
		end
	endfunction

	// Idle gap length: mostly none, sometimes short, now and then long.
	function automatic int draw_pause(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one byte request and waits for it to be taken. Valid stays high into the next
	// request when no gap is drawn, so it is never lowered and raised in one step.
	task automatic offer_byte(input logic [7:0] b, input logic eof, input bit typed,
		input status_t typed_st);
		int pause;
		reg_result_t r;
		in_valid <= 1'b1;
		rx_byte <= b;
		end_of_frame <= eof;
		do @(posedge clk); while (!in_ready);
		frame_step(b, eof);
		if (typed && eof) begin
			// The directed table states this outcome outright.
			r.st = typed_st;
			r.idx = '0;
			r.val = '0;
			r.last = 1'b1;
			awaited.push_back(r);
		end else begin
			foreach (fresh_results[k])
				awaited.push_back(fresh_results[k]);
		end
		fresh_results.delete();
		pause = draw_pause(sender_steady);
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	task automatic send_frame(input bit typed, input status_t typed_st);
		int i;
		for (i = 0; i < frame_bytes.size(); i++)
			offer_byte(frame_bytes[i], i == frame_bytes.size() - 1, typed, typed_st);
	endtask

	// Lets the block drain: every awaited result out, then time for any work still going on.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back. Unused upper data bits carry noise, which the
	// block must drop.
	task automatic apply_config(input logic [15:0] addr, input logic two, input logic [7:0] fc,
		input logic [5:0] cnt);
		logic [CFG_IDX_W-1:0] idx_list[4];
		logic [15:0] vals[4];
		int i;
		idx_list[0] = CFG_EXP_ADDR;
		idx_list[1] = CFG_ADDR_TWO;
		idx_list[2] = CFG_FUNC;
		idx_list[3] = CFG_REG_CNT;
		vals[0] = addr;
		vals[1] = {15'($urandom), two};
		vals[2] = {8'($urandom), fc};
		vals[3] = {10'($urandom), cnt};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[i])
				CFG_EXP_ADDR: cfg_addr = vals[i];
				CFG_ADDR_TWO: cfg_two = vals[i][0];
				CFG_FUNC: cfg_func = vals[i][7:0];
				CFG_REG_CNT: cfg_count = vals[i][5:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Result side: random ready with short and long stalls, stretches with none, and one
	// long hold-off on request so that the block backs up and stalls its input.
	initial begin : result_sink
		int stall_left;
		bit steady;
		stall_left = 0;
		steady = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				steady = ~steady;
			if (backlog_req) begin
				backlog_req = 1'b0;
				out_ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = draw_pause(steady);
			end
		end
	end

	// Every accepted result is compared with the oldest one awaited, field by field.
	always @(posedge clk) begin : result_check
		reg_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$error("result with none awaited: status %0d index %0d value %h last %0d",
					status, reg_index, reg_value, last);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (status !== want.st) begin
					$error("status mismatch: expected %0d, actual %0d", want.st, status);
					mismatches++;
				end
				if (reg_index !== want.idx) begin
					$error("reg_index mismatch: expected %0d, actual %0d", want.idx, reg_index);
					mismatches++;
				end
				if (reg_value !== want.val) begin
					$error("reg_value mismatch: expected %h, actual %h", want.val, reg_value);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on any channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		directed_row_t v;
		frame_kind_t kind;
		fill_t fill;
		logic [5:0] n_sel;
		int row;
		int phase;
		int frames;
		int f;
		int r;
		int random_bytes;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_EXP_ADDR;
		cfg_data <= '0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		end_of_frame <= 1'b0;

		// The first row runs on the reset configuration, so no write comes before it. The
		// typed rows are error cases whose status is plain from the frame alone.
		directed_rows[0] = '{16'h0001, 1'b0, 8'h03, 6'd1, FR_GOOD, FILL_ONES, 1'b0, ST_OK};
		directed_rows[1] = '{16'h0001, 1'b0, 8'h03, 6'd1, FR_BAD_CRC, FILL_RANDOM, 1'b1, ST_CRC};
		directed_rows[2] = '{16'hFFFF, 1'b0, 8'hFF, 6'd1, FR_BAD_ADDR, FILL_ZERO, 1'b1,
			ST_ADDRESS};
		directed_rows[3] = '{16'h0000, 1'b1, 8'h00, 6'd1, FR_BAD_FUNC, FILL_RANDOM, 1'b1, ST_FUNC};
		directed_rows[4] = '{16'hA55A, 1'b1, 8'h03, 6'd1, FR_BAD_COUNT, FILL_ONES, 1'b1, ST_COUNT};
		directed_rows[5] = '{16'hFFFF, 1'b1, 8'hFF, 6'd1, FR_GOOD, FILL_ZERO, 1'b0, ST_OK};
		// A register count of zero or above the buffer size fails every frame on length.
		directed_rows[6] = '{16'h0001, 1'b0, 8'h03, 6'd0, FR_STUB, FILL_RANDOM, 1'b1, ST_LENGTH};
		directed_rows[7] = '{16'h0001, 1'b0, 8'h03, 6'd63, FR_STUB, FILL_RANDOM, 1'b1, ST_LENGTH};

		cfg_addr = 16'h0001;
		cfg_two = 1'b0;
		cfg_func = 8'h03;
		cfg_count = 6'd1;
		clear_frame();
		foreach (reg_buf[i])
			reg_buf[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			v = directed_rows[row];
			if (v.addr != cfg_addr || v.two != cfg_two || v.fc != cfg_func || v.cnt != cfg_count) begin
				wait_idle();
				apply_config(v.addr, v.two, v.fc, v.cnt);
			end
			build_frame(v.kind, v.fill);
			send_frame(v.typed, v.st);
		end

		// Random phases: a fresh configuration each time, mostly well-formed frames with
		// random contents, the rest broken headers, bad lengths and line noise.
		random_bytes = 0;
		phase = 0;
		while (random_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 19);
			if (phase == 0 || r == 2)
				n_sel = 6'd32;
			else if (r == 0)
				n_sel = 6'd0;
			else if (r == 1)
				n_sel = 6'($urandom_range(33, 63));
			else if (r < 6)
				n_sel = 6'($urandom_range(5, 31));
			else
				n_sel = 6'($urandom_range(1, 4));
			wait_idle();
			apply_config(16'($urandom), 1'($urandom), 8'($urandom), n_sel);
			sender_steady = ($urandom_range(0, 3) == 0);
			// The second phase runs against a long receiver hold-off.
			if (phase == 1)
				backlog_req = 1'b1;

			frames = (n_sel > 8 && n_sel <= MAX_REGS) ? 2 : $urandom_range(3, 8);
			for (f = 0; f < frames; f++) begin
				r = $urandom_range(0, 99);
				if (phase == 0 && f == 0) kind = FR_GOOD;
				else if (r < 55) kind = FR_GOOD;
				else if (r < 62) kind = FR_BAD_CRC;
				else if (r < 68) kind = FR_BAD_ADDR;
				else if (r < 74) kind = FR_BAD_FUNC;
				else if (r < 80) kind = FR_BAD_COUNT;
				else if (r < 88) kind = FR_BAD_LEN;
				else if (r < 96) kind = FR_NOISE;
				else kind = FR_STUB;
				r = $urandom_range(0, 9);
				fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
				build_frame(kind, fill);
				random_bytes += frame_bytes.size();
				send_frame(1'b0, ST_OK);
			end
			phase++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/mrrc_pkg.sv
hdl/mrrc_crc.sv
hdl/mrrc_regfile.sv
hdl/modbus_read_response_checker_core.sv
sim/testbench.sv
